/* hw/rtl/fir_pkg.sv */
// Shared types, sizes and codes for the Q31 x Q15 FIR filter.
package fir_pkg;

	localparam int MAX_TAPS      = 256;
	localparam int ADDR_W        = $clog2(MAX_TAPS);
	localparam int CNT_W         = $clog2(MAX_TAPS + 1);
	localparam int PRODUCT_SHIFT = 15;
	localparam int GROUP_LOG2    = 2;   // four taps per group
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 8;

	typedef logic [ADDR_W-1:0]    tap_addr_t;
	typedef logic [CNT_W-1:0]     tap_cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	localparam logic       CMD_SAMPLE = 1'b0;
	localparam logic       CMD_COEF   = 1'b1;

	localparam cfg_index_t REG_TAP_GROUPS   = cfg_index_t'(0);
	localparam cfg_index_t REG_OUTPUT_SHIFT = cfg_index_t'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_DONE
	} fir_state_t;

	// Tag that travels with each tap read through the MAC pipeline.
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} tap_ctl_t;

endpackage

/* hw/rtl/fir_filter_q31_q15.sv */
// Top level of the Q31 x Q15 FIR filter: command intake, history and coefficient memories.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall    | cmd, sample_in, coef_index, coef_value
//  out     | output    | out_valid / out_stall  | sample_out
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A filtered sample with N = 4 * tap_groups taps (at most MAX_TAPS) walks its N taps through
// the MAC pipeline; the history memory has one read port, so one tap is read and multiplied
// per cycle. A bypass sample skips the tap walk; a coefficient load writes the coefficient memory.
// Reset clears the configuration, the write pointer and the per-entry history valid bits.
// A stalled result holds in the output register; the next item is taken meanwhile and
// waits for the register only when its own result is ready.
module fir_filter_q31_q15 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic signed [31:0]             sample_in,
	input  logic [7:0]                     coef_index,
	input  logic signed [15:0]             coef_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [31:0]             sample_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  fir_pkg::cfg_index_t            cfg_index,
	input  logic [fir_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fir_pkg::*;

	fir_state_t state_q, state_d;

	logic [6:0] tap_groups_q;
	logic [4:0] output_shift_q;

	logic signed [31:0] hist_mem [MAX_TAPS];
	logic signed [15:0] coef_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0] hist_vld_q;

	tap_addr_t wp_q;
	tap_addr_t slot_q;
	tap_cnt_t  k_q;
	tap_cnt_t  taps_q;
	tap_cnt_t  taps_cfg;
	logic [31:0] taps_raw;

	logic in_xfer, sample_xfer, coef_xfer, bypass;
	logic hist_we, coef_we, out_load, issue_last;
	tap_ctl_t issue, ctl_s1;

	logic signed [31:0] hist_rd_s1;
	logic               hist_vld_s1;
	logic signed [31:0] hist_masked_s1;
	logic signed [15:0] coef_rd_s1;
	logic signed [31:0] result_q;
	logic               mac_vld;
	logic signed [31:0] mac_res;

	assign cfg_ready = 1'b1;

	assign in_xfer     = in_valid & ~in_stall;
	assign sample_xfer = in_xfer & (cmd == CMD_SAMPLE);
	assign coef_xfer   = in_xfer & (cmd == CMD_COEF);
	assign bypass      = (tap_groups_q == '0);

	assign taps_raw = 32'({tap_groups_q, {GROUP_LOG2{1'b0}}});
	assign taps_cfg = (taps_raw > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(taps_raw);
	assign issue_last = (k_q + CNT_W'(1) == taps_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_groups_q   <= '0;
			output_shift_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TAP_GROUPS:   tap_groups_q   <= cfg_data[6:0];
				REG_OUTPUT_SHIFT: output_shift_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_xfer) begin
					state_d = bypass ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (mac_vld) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		hist_we  = 1'b0;
		coef_we  = 1'b0;
		out_load = 1'b0;
		issue    = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				hist_we  = sample_xfer & ~bypass;
				coef_we  = coef_xfer & (32'(coef_index) < 32'(MAX_TAPS));
			end
			ST_RUN: begin
				issue.vld   = 1'b1;
				issue.first = (k_q == '0);
				issue.last  = issue_last;
			end
			ST_WAIT: ;
			ST_DONE: begin
				out_load = ~out_valid | ~out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			hist_vld_q <= '0;
			ctl_s1     <= '0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			ctl_s1  <= issue;
			if (hist_we) begin
				hist_vld_q[wp_q] <= 1'b1;
				wp_q <= (wp_q == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_q + ADDR_W'(1);
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// tap walk: slot steps back through the ring from the newest sample
	always_ff @(posedge clk) begin
		if (hist_we) begin
			slot_q <= wp_q;
			k_q    <= '0;
			taps_q <= taps_cfg;
		end else if (issue.vld) begin
			slot_q <= (slot_q == '0) ? ADDR_W'(MAX_TAPS - 1) : slot_q - ADDR_W'(1);
			k_q    <= k_q + CNT_W'(1);
		end
		if (sample_xfer && bypass) begin
			result_q <= sample_in;
		end else if (state_q == ST_WAIT && mac_vld) begin
			result_q <= mac_res;
		end
		if (out_load) begin
			sample_out <= result_q;
		end
	end

	// history memory and its valid bits
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[wp_q] <= sample_in;
		end
		hist_rd_s1  <= hist_mem[slot_q];
		hist_vld_s1 <= hist_vld_q[slot_q];
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[ADDR_W'(coef_index)] <= coef_value;
		end
		coef_rd_s1 <= coef_mem[k_q[ADDR_W-1:0]];
	end

	// never-written history slots read as zero
	assign hist_masked_s1 = hist_vld_s1 ? hist_rd_s1 : '0;

	fir_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.coef_s1      (coef_rd_s1),
		.hist_s1      (hist_masked_s1),
		.output_shift (output_shift_q),
		.res_vld      (mac_vld),
		.res_data     (mac_res)
	);

	a_mac_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_vld |-> state_q == ST_WAIT)
		else $error("MAC result outside of wait state");

	a_issue_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.vld |-> $past(state_q == ST_RUN))
		else $error("tap read issued outside of run state");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> k_q < taps_q)
		else $error("tap counter past active tap count");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("output transfer raised without a finished result");

endmodule

/* hw/rtl/fir_mac.sv */
// Multiply-accumulate pipeline with floor shift and 32-bit saturation.
module fir_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  fir_pkg::tap_ctl_t  ctl_s1,
	input  logic signed [15:0] coef_s1,
	input  logic signed [31:0] hist_s1,
	input  logic [4:0]         output_shift,
	output logic               res_vld,
	output logic signed [31:0] res_data
);
	import fir_pkg::*;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	tap_ctl_t           ctl_s2;
	logic signed [47:0] prod_s2;
	logic signed [63:0] acc_s3;
	logic               done_s3;
	logic signed [63:0] sh_s4;
	logic               done_s4;
	logic [5:0]         shamt;

	assign shamt = 6'(PRODUCT_SHIFT) + 6'(output_shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			done_s3 <= 1'b0;
			done_s4 <= 1'b0;
			res_vld <= 1'b0;
		end else begin
			ctl_s2  <= ctl_s1;
			done_s3 <= ctl_s2.vld & ctl_s2.last;
			done_s4 <= done_s3;
			res_vld <= done_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= hist_s1 * coef_s1;
		if (ctl_s2.vld) begin
			if (ctl_s2.first) begin
				acc_s3 <= {{16{prod_s2[47]}}, prod_s2};
			end else begin
				acc_s3 <= acc_s3 + {{16{prod_s2[47]}}, prod_s2};
			end
		end
		// arithmetic shift rounds toward minus infinity
		sh_s4 <= acc_s3 >>> shamt;
		if (sh_s4 > SAT_MAX) begin
			res_data <= SAT_MAX[31:0];
		end else if (sh_s4 < SAT_MIN) begin
			res_data <= SAT_MIN[31:0];
		end else begin
			res_data <= sh_s4[31:0];
		end
	end

endmodule
